// ===== hdl/string_key_index_hash_unit_macros.svh =====
// Assertion macros shared by the string key index hash unit.
`ifndef STRING_KEY_INDEX_HASH_UNIT_MACROS_SVH
`define STRING_KEY_INDEX_HASH_UNIT_MACROS_SVH

// Implication checked in the same cycle.
`define SKIH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("skih check failed");

// Implication checked in the cycle after the antecedent.
`define SKIH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("skih check failed");

`endif

// ===== hdl/skih_pkg.sv =====
// Package with default sizes and status codes of the string key index hash unit.
package skih_pkg;

  localparam int SKIH_BUCKETS     = 101;
  localparam int SKIH_MAX_ENTRIES = 256;
  localparam int SKIH_MAX_KEY_LEN = 32;

  typedef enum logic [2:0] {
    ST_NEW       = 3'd0,
    ST_DUP       = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

endpackage

// ===== hdl/skih_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module skih_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/string_key_index_hash_unit.sv =====
// Top level of the string key index hash unit.
// Keys arrive one character per item and are hashed at one item per cycle while in_stall
// is low. After the last character the block stalls its input while it walks the bucket
// chain: it reads the bucket head (S_HRD, S_HEAD), then per visited entry its length and
// link (S_ERD, S_ELEN) and each compared character (S_CRD, S_CHR); a walk that ends with no
// match passes S_ERD once more, and a new key is stored one character at a time (S_IRD,
// S_IWR). S_OUT then loads the output register, waiting while the previous result is still
// held there. A key that ran past the maximum length skips the walk (S_HRD, then S_OUT).
// After reset the bucket heads are cleared in a pass during which no item is accepted.
`include "string_key_index_hash_unit_macros.svh"

module string_key_index_hash_unit #(
  parameter int BUCKETS     = skih_pkg::SKIH_BUCKETS,
  parameter int MAX_ENTRIES = skih_pkg::SKIH_MAX_ENTRIES,
  parameter int MAX_KEY_LEN = skih_pkg::SKIH_MAX_KEY_LEN
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_action,
  input  logic [6:0]        in_key_char,
  input  logic              in_last_char,
  output logic              out_valid,
  input  logic              out_stall,
  output skih_pkg::status_t out_status,
  output logic [7:0]        out_entry_index
);
  import skih_pkg::*;

  localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int EW  = $clog2(MAX_ENTRIES + 1);
  localparam int EA  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int LW  = $clog2(MAX_KEY_LEN + 1);
  localparam int PW  = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
  localparam int CD  = MAX_ENTRIES * MAX_KEY_LEN;
  localparam int CAW = (CD > 1) ? $clog2(CD) : 1;
  localparam int XW  = BW + 8;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_HRD, S_HEAD, S_ERD, S_ELEN, S_CRD, S_CHR, S_IRD, S_IWR, S_OUT
  } state_t;

  state_t            state_r;
  logic [BW-1:0]     clr_r;
  logic [BW-1:0]     hash_r;
  logic [BW-1:0]     hash_nxt;
  logic [LW-1:0]     plen_r;
  logic              pact_r;
  logic              tlong_r;
  logic [EW-1:0]     used_r;
  logic [EW-1:0]     cur_r;
  logic [EW-1:0]     head_r;
  logic [EW-1:0]     nxte_r;
  logic [EW-1:0]     steps_r;
  logic [LW-1:0]     i_r;
  status_t           res_status_r;
  logic [7:0]        res_idx_r;
  logic              out_valid_r;
  status_t           out_status_r;
  logic [7:0]        out_idx_r;

  logic              in_acc;
  logic              ins_done;
  logic [XW-1:0]     hx;

  logic              head_we;
  logic [BW-1:0]     head_waddr;
  logic [EW-1:0]     head_wdata;
  logic [EW-1:0]     head_rdata;
  logic              ent_we;
  logic [EW-1:0]     next_rdata;
  logic [LW-1:0]     len_rdata;
  logic              chr_we;
  logic [CAW-1:0]    chr_waddr;
  logic [CAW-1:0]    chr_raddr;
  logic [6:0]        chr_rdata;
  logic              pnd_we;
  logic [6:0]        pnd_rdata;

  function automatic logic [CAW-1:0] char_addr(input logic [EW-1:0] e, input logic [LW-1:0] i);
    char_addr = CAW'(e) * CAW'(MAX_KEY_LEN) + CAW'(i);
  endfunction

  always_comb begin
    hx = (XW'(hash_r) << 7) + XW'(in_key_char);
    for (int k = 7; k >= 0; k--) begin
      if (hx >= (XW'(BUCKETS) << k)) begin
        hx = hx - (XW'(BUCKETS) << k);
      end
    end
    hash_nxt = hx[BW-1:0];
  end

  assign in_stall   = (state_r != S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign ins_done   = (i_r + LW'(1) == plen_r);

  assign head_we    = (state_r == S_CLR) || ((state_r == S_IWR) && ins_done);
  assign head_waddr = (state_r == S_CLR) ? clr_r : hash_r;
  assign head_wdata = (state_r == S_CLR) ? EW'(MAX_ENTRIES) : used_r;
  assign ent_we     = (state_r == S_IWR) && ins_done;
  assign chr_we     = (state_r == S_IWR);
  assign chr_waddr  = char_addr(used_r, i_r);
  assign chr_raddr  = char_addr(cur_r, i_r);
  assign pnd_we     = in_acc && (plen_r < LW'(MAX_KEY_LEN));

  skih_ram #(.WIDTH(EW), .DEPTH(BUCKETS)) u_head_ram (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(hash_r), .rdata(head_rdata)
  );

  skih_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_next_ram (
    .clk(clk), .we(ent_we), .waddr(used_r[EA-1:0]), .wdata(head_r),
    .raddr(cur_r[EA-1:0]), .rdata(next_rdata)
  );

  skih_ram #(.WIDTH(LW), .DEPTH(MAX_ENTRIES)) u_len_ram (
    .clk(clk), .we(ent_we), .waddr(used_r[EA-1:0]), .wdata(plen_r),
    .raddr(cur_r[EA-1:0]), .rdata(len_rdata)
  );

  skih_ram #(.WIDTH(7), .DEPTH(CD)) u_chr_ram (
    .clk(clk), .we(chr_we), .waddr(chr_waddr), .wdata(pnd_rdata),
    .raddr(chr_raddr), .rdata(chr_rdata)
  );

  skih_ram #(.WIDTH(7), .DEPTH(MAX_KEY_LEN)) u_pnd_ram (
    .clk(clk), .we(pnd_we), .waddr(plen_r[PW-1:0]), .wdata(in_key_char),
    .raddr(i_r[PW-1:0]), .rdata(pnd_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      hash_r      <= '0;
      plen_r      <= '0;
      pact_r      <= 1'b0;
      tlong_r     <= 1'b0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + BW'(1);
          if (clr_r == BW'(BUCKETS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            if (plen_r == '0 && !tlong_r) begin
              pact_r <= in_action;
            end
            hash_r <= hash_nxt;
            if (plen_r < LW'(MAX_KEY_LEN)) begin
              plen_r <= plen_r + LW'(1);
            end else begin
              tlong_r <= 1'b1;
            end
            if (in_last_char) begin
              state_r <= S_HRD;
            end
          end
        end
        S_HRD: begin
          if (tlong_r) begin
            res_status_r <= ST_OVERFLOW;
            res_idx_r    <= '0;
            state_r      <= S_OUT;
          end else begin
            state_r <= S_HEAD;
          end
        end
        S_HEAD: begin
          head_r  <= head_rdata;
          cur_r   <= head_rdata;
          steps_r <= '0;
          state_r <= S_ERD;
        end
        S_ERD: begin
          if (cur_r >= EW'(MAX_ENTRIES) || steps_r >= used_r) begin
            res_idx_r <= '0;
            if (pact_r) begin
              res_status_r <= ST_NOT_FOUND;
              state_r      <= S_OUT;
            end else if (used_r == EW'(MAX_ENTRIES)) begin
              res_status_r <= ST_OVERFLOW;
              state_r      <= S_OUT;
            end else begin
              i_r     <= '0;
              state_r <= S_IRD;
            end
          end else begin
            state_r <= S_ELEN;
          end
        end
        S_ELEN: begin
          nxte_r <= next_rdata;
          if (len_rdata != plen_r) begin
            cur_r   <= next_rdata;
            steps_r <= steps_r + EW'(1);
            state_r <= S_ERD;
          end else begin
            i_r     <= '0;
            state_r <= S_CRD;
          end
        end
        S_CRD: begin
          state_r <= S_CHR;
        end
        S_CHR: begin
          if (chr_rdata != pnd_rdata) begin
            cur_r   <= nxte_r;
            steps_r <= steps_r + EW'(1);
            state_r <= S_ERD;
          end else if (ins_done) begin
            res_status_r <= pact_r ? ST_FOUND : ST_DUP;
            res_idx_r    <= 8'(cur_r);
            state_r      <= S_OUT;
          end else begin
            i_r     <= i_r + LW'(1);
            state_r <= S_CRD;
          end
        end
        S_IRD: begin
          state_r <= S_IWR;
        end
        S_IWR: begin
          if (ins_done) begin
            res_status_r <= ST_NEW;
            res_idx_r    <= 8'(used_r);
            used_r       <= used_r + EW'(1);
            state_r      <= S_OUT;
          end else begin
            i_r     <= i_r + LW'(1);
            state_r <= S_IRD;
          end
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_status_r <= res_status_r;
            out_idx_r    <= res_idx_r;
            hash_r       <= '0;
            plen_r       <= '0;
            pact_r       <= 1'b0;
            tlong_r      <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_index = out_idx_r;

  `SKIH_ASSERT_IMP(a_used_bound, 1'b1, used_r <= EW'(MAX_ENTRIES))
  `SKIH_ASSERT_IMP(a_clr_stalls, state_r == S_CLR, in_stall)
  `SKIH_ASSERT_IMP(a_err_zero, out_valid_r && out_status_r == ST_OVERFLOW, out_idx_r == 8'd0)
  `SKIH_ASSERT_NXT(a_used_step, used_r != EW'(MAX_ENTRIES) && state_r != S_IWR,
                   used_r == $past(used_r))
endmodule
